// ===== hdl/wbcs_pkg.sv =====
// Shared types, constants and register codes of the weighted border color sampler.
package wbcs_pkg;

    localparam int DIM_BITS     = 10;
    localparam int CNT_BITS     = 8;
    localparam int LED_BITS     = 10;
    localparam int COL_BITS     = 8;
    localparam int WGT_BITS     = 16;
    localparam int PROD_BITS    = 24;
    localparam int WSUM_BITS    = 32;
    localparam int CSUM_BITS    = 40;
    localparam int SPAN_BITS    = 20;
    localparam int CFG_IDX_BITS = 3;
    localparam int MAX_LEDS_DEF = 1024;

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_FRAME = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THICK  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT  = 3'd7;

    localparam logic [DIM_BITS-1:0] RST_WIDTH  = 10'd320;
    localparam logic [DIM_BITS-1:0] RST_HEIGHT = 10'd180;
    localparam logic [DIM_BITS-1:0] RST_THICK  = 10'd18;
    localparam logic [CNT_BITS-1:0] RST_TOP    = 8'd16;
    localparam logic [CNT_BITS-1:0] RST_RIGHT  = 8'd9;
    localparam logic [CNT_BITS-1:0] RST_BOTTOM = 8'd16;
    localparam logic [CNT_BITS-1:0] RST_LEFT   = 8'd9;
    localparam logic [LED_BITS-1:0] RST_SHIFT  = 10'd0;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [DIM_BITS-1:0] thick;
        logic [CNT_BITS-1:0] top;
        logic [CNT_BITS-1:0] right;
        logic [CNT_BITS-1:0] bottom;
        logic [CNT_BITS-1:0] left;
        logic [LED_BITS-1:0] shift;
    } t_cfg;

    typedef struct packed {
        logic [WGT_BITS-1:0]  wgt;
        logic [PROD_BITS-1:0] prod_b;
        logic [PROD_BITS-1:0] prod_g;
        logic [PROD_BITS-1:0] prod_r;
    } t_pixel;

    typedef struct packed {
        logic                 tag;
        logic [WSUM_BITS-1:0] wsum;
        logic [CSUM_BITS-1:0] bsum;
        logic [CSUM_BITS-1:0] gsum;
        logic [CSUM_BITS-1:0] rsum;
    } t_entry;

endpackage

// ===== hdl/wbcs_scan.sv =====
// Region scanner: steps through the LEDs of each side and reports the regions holding a pixel.
module wbcs_scan #(
    parameter int MAX_LEDS = wbcs_pkg::MAX_LEDS_DEF,
    localparam int AW = $clog2(MAX_LEDS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  wbcs_pkg::t_cfg                i_cfg,
    input  logic [wbcs_pkg::DIM_BITS-1:0] i_x,
    input  logic [wbcs_pkg::DIM_BITS-1:0] i_y,
    input  logic                          i_hit_ready,
    output logic                          o_hit_valid,
    output logic [AW-1:0]                 o_hit_idx,
    output logic                          o_busy
);

    localparam int DB = wbcs_pkg::DIM_BITS;
    localparam int CB = wbcs_pkg::CNT_BITS;
    localparam int LB = wbcs_pkg::LED_BITS;
    localparam int SB = wbcs_pkg::SPAN_BITS;

    typedef enum logic [1:0] {SC_IDLE, SC_SETUP, SC_STEP} t_state;
    typedef enum logic [1:0] {SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT} t_side;

    t_state          r_state;
    t_side           r_side;
    logic [DB-1:0]   r_x, r_y;
    logic [CB-1:0]   r_k;
    logic [SB-1:0]   r_span, r_lo, r_hi;

    logic [CB-1:0]   w_n;
    logic [DB-1:0]   w_dim, w_p;
    logic            w_on, w_rev;
    logic [LB-1:0]   w_base;
    logic [DB-1:0]   w_min_dh, w_min_dw, w_w_band, w_h_band;
    logic [SB-1:0]   w_lo, w_next;
    logic            w_match, w_in_range, w_advance;
    logic [CB-1:0]   w_off;
    logic [LB-1:0]   w_idx;

    assign w_min_dh = (i_cfg.thick < i_cfg.height) ? i_cfg.thick : i_cfg.height;
    assign w_min_dw = (i_cfg.thick < i_cfg.width) ? i_cfg.thick : i_cfg.width;
    assign w_w_band = (i_cfg.width > i_cfg.thick) ? i_cfg.width - i_cfg.thick : '0;
    assign w_h_band = (i_cfg.height > i_cfg.thick) ? i_cfg.height - i_cfg.thick : '0;

    always_comb begin
        case (r_side)
            SIDE_TOP: begin
                w_n = i_cfg.top;  w_dim = i_cfg.width;  w_p = r_x;
                w_on = r_y < w_min_dh;  w_rev = 1'b0;  w_base = '0;
            end
            SIDE_RIGHT: begin
                w_n = i_cfg.right;  w_dim = i_cfg.height;  w_p = r_y;
                w_on = r_x >= w_w_band;  w_rev = 1'b0;  w_base = LB'(i_cfg.top);
            end
            SIDE_BOTTOM: begin
                w_n = i_cfg.bottom;  w_dim = i_cfg.width;  w_p = r_x;
                w_on = r_y >= w_h_band;  w_rev = 1'b1;
                w_base = LB'(i_cfg.top) + LB'(i_cfg.right);
            end
            default: begin
                w_n = i_cfg.left;  w_dim = i_cfg.height;  w_p = r_y;
                w_on = r_x < w_min_dw;  w_rev = 1'b1;
                w_base = LB'(i_cfg.top) + LB'(i_cfg.right) + LB'(i_cfg.bottom);
            end
        endcase
    end

    assign w_lo   = SB'(w_p) * SB'({w_n, 1'b0});
    assign w_next = r_span + SB'({w_dim, 1'b0});

    // The region starts at or before the pixel and ends after it, or it is a
    // single pixel wide and sits exactly on the pixel.
    assign w_match = ((r_span < r_hi) && (w_next >= r_hi)) ||
                     ((r_span < r_hi) && (r_span >= r_lo) &&
                      (w_next >= r_lo) && (w_next < r_hi));

    assign w_off      = w_rev ? (w_n - CB'(1) - r_k) : r_k;
    assign w_idx      = w_base + LB'(w_off);
    assign w_in_range = int'(w_idx) < MAX_LEDS;

    assign o_hit_valid = (r_state == SC_STEP) && w_match && w_in_range;
    assign o_hit_idx   = AW'(w_idx);
    assign o_busy      = r_state != SC_IDLE;
    assign w_advance   = !o_hit_valid || i_hit_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_side  <= SIDE_TOP;
        end else begin
            case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_y     <= i_y;
                        r_side  <= SIDE_TOP;
                        r_state <= SC_SETUP;
                    end
                end
                SC_SETUP: begin
                    if (w_on && (w_n != '0)) begin
                        r_lo    <= w_lo;
                        r_hi    <= w_lo + SB'({w_n, 1'b0});
                        r_span  <= SB'(w_n);
                        r_k     <= '0;
                        r_state <= SC_STEP;
                    end else if (r_side == SIDE_LEFT) begin
                        r_state <= SC_IDLE;
                    end else begin
                        r_side <= t_side'(r_side + 1'b1);
                    end
                end
                SC_STEP: begin
                    if (w_advance) begin
                        if (r_k == w_n - CB'(1)) begin
                            if (r_side == SIDE_LEFT) begin
                                r_state <= SC_IDLE;
                            end else begin
                                r_side  <= t_side'(r_side + 1'b1);
                                r_state <= SC_SETUP;
                            end
                        end else begin
                            r_k    <= r_k + CB'(1);
                            r_span <= w_next;
                        end
                    end
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/wbcs_mem.sv =====
// Per-LED sum store with frame tags, saturating read-modify-write and a clearing pass.
module wbcs_mem #(
    parameter int MAX_LEDS = wbcs_pkg::MAX_LEDS_DEF,
    localparam int AW = $clog2(MAX_LEDS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_frame,
    input  logic               i_acc_valid,
    input  logic [AW-1:0]      i_acc_idx,
    input  wbcs_pkg::t_pixel   i_pix,
    output logic               o_acc_ready,
    input  logic               i_rd_valid,
    input  logic [AW-1:0]      i_rd_idx,
    output logic               o_rd_done,
    output wbcs_pkg::t_entry   o_entry,
    output logic               o_live,
    output logic               o_ready
);

    localparam int WB = wbcs_pkg::WSUM_BITS;
    localparam int CS = wbcs_pkg::CSUM_BITS;

    typedef enum logic [1:0] {M_CLEAR, M_IDLE, M_ACC, M_RD} t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr, r_idx;
    logic              r_parity;
    wbcs_pkg::t_entry  r_rdata;
    wbcs_pkg::t_entry  r_mem [MAX_LEDS];

    logic              w_ren, w_wen;
    logic [AW-1:0]     w_raddr, w_waddr;
    wbcs_pkg::t_entry  w_base, w_acc, w_wdata;
    logic [WB:0]       w_wsum;
    logic [CS:0]       w_bsum, w_gsum, w_rsum;

    assign o_live  = r_rdata.tag == r_parity;
    assign w_base  = o_live ? r_rdata : '0;
    assign w_wsum  = (WB+1)'(w_base.wsum) + (WB+1)'(i_pix.wgt);
    assign w_bsum  = (CS+1)'(w_base.bsum) + (CS+1)'(i_pix.prod_b);
    assign w_gsum  = (CS+1)'(w_base.gsum) + (CS+1)'(i_pix.prod_g);
    assign w_rsum  = (CS+1)'(w_base.rsum) + (CS+1)'(i_pix.prod_r);

    always_comb begin
        w_acc.tag  = r_parity;
        w_acc.wsum = w_wsum[WB] ? '1 : w_wsum[WB-1:0];
        w_acc.bsum = w_bsum[CS] ? '1 : w_bsum[CS-1:0];
        w_acc.gsum = w_gsum[CS] ? '1 : w_gsum[CS-1:0];
        w_acc.rsum = w_rsum[CS] ? '1 : w_rsum[CS-1:0];
    end

    assign w_ren   = (r_state == M_IDLE) && (i_acc_valid || i_rd_valid);
    assign w_raddr = i_acc_valid ? i_acc_idx : i_rd_idx;
    assign w_wen   = (r_state == M_CLEAR) || (r_state == M_ACC);
    assign w_waddr = (r_state == M_CLEAR) ? r_clr : r_idx;
    assign w_wdata = (r_state == M_CLEAR) ? '0 : w_acc;

    assign o_acc_ready = r_state == M_IDLE;
    assign o_rd_done   = r_state == M_RD;
    assign o_entry     = r_rdata;
    assign o_ready     = r_state != M_CLEAR;

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_ren) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= M_CLEAR;
            r_clr    <= '0;
            r_parity <= 1'b1;
        end else begin
            if (i_frame) begin
                r_parity <= !r_parity;
            end
            case (r_state)
                M_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAX_LEDS - 1)) begin
                        r_state <= M_IDLE;
                    end
                end
                M_IDLE: begin
                    if (i_acc_valid) begin
                        r_idx   <= i_acc_idx;
                        r_state <= M_ACC;
                    end else if (i_rd_valid) begin
                        r_state <= M_RD;
                    end
                end
                M_ACC:   r_state <= M_IDLE;
                M_RD:    r_state <= M_IDLE;
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/wbcs_div.sv =====
// Restoring divider giving the rounded weighted mean of one color, one quotient bit a cycle.
module wbcs_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wbcs_pkg::CSUM_BITS-1:0] i_sum,
    input  logic [wbcs_pkg::WSUM_BITS-1:0] i_wgt,
    output logic                           o_done,
    output logic [wbcs_pkg::COL_BITS-1:0]  o_mean
);

    localparam int CS = wbcs_pkg::CSUM_BITS;
    localparam int WB = wbcs_pkg::WSUM_BITS;
    localparam int QB = wbcs_pkg::COL_BITS + 1;
    localparam int RB = CS + 2;

    logic            r_busy, r_done;
    logic [RB-1:0]   r_rem;
    logic [WB:0]     r_div;
    logic [QB-1:0]   r_q;
    logic [3:0]      r_j;

    logic [RB-1:0]   w_cand;
    logic            w_ge;

    assign w_cand = RB'(r_div) << r_j;
    assign w_ge   = r_rem >= w_cand;
    assign o_done = r_done;
    assign o_mean = r_q[QB-1] ? '1 : r_q[QB-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_sum, 1'b0} + RB'(i_wgt);
                r_div  <= {i_wgt, 1'b0};
                r_q    <= '0;
                r_j    <= 4'(QB - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - w_cand;
                end
                r_q <= {r_q[QB-2:0], w_ge};
                r_j <= r_j - 4'd1;
                if (r_j == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/weighted_border_color_sampler.sv =====
// Top level of the weighted border color sampler: configuration, sequencer and output register.
//
// Input channel (i_in_valid/o_in_ready) takes one transaction per item: a pixel,
// a start of frame, or a read of one strip position. Pixels come in raster order.
// The output channel (o_out_valid/i_out_ready) gives one color per read only.
// The configuration channel writes register i_cfg_index with i_cfg_data and is
// always ready; write it only while the block is idle, which the block does not enforce.
// A pixel's time is set by the region scanner, which tests one LED a cycle while the
// sum memory takes its hits, and by the read-modify-write of the sum memory. A read
// works out the rotation remainder, reads the memory once, then runs the one shared
// divider for each of the three colors in turn. After reset a clearing pass writes
// every memory entry; no input is taken during it. When the receiver stalls, the
// result waits in the output register and the next input is still taken; a later
// read holds in its last state until the output register is free.
module weighted_border_color_sampler #(
    parameter int MAX_LEDS = wbcs_pkg::MAX_LEDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic [wbcs_pkg::COL_BITS-1:0]     i_pixel_blue,
    input  logic [wbcs_pkg::COL_BITS-1:0]     i_pixel_green,
    input  logic [wbcs_pkg::COL_BITS-1:0]     i_pixel_red,
    input  logic [wbcs_pkg::WGT_BITS-1:0]     i_pixel_weight,
    input  logic [wbcs_pkg::LED_BITS-1:0]     i_strip_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wbcs_pkg::COL_BITS-1:0]     o_led_blue,
    output logic [wbcs_pkg::COL_BITS-1:0]     o_led_green,
    output logic [wbcs_pkg::COL_BITS-1:0]     o_led_red,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbcs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [wbcs_pkg::DIM_BITS-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_LEDS);
    localparam int DB = wbcs_pkg::DIM_BITS;
    localparam int LB = wbcs_pkg::LED_BITS;
    localparam int CB = wbcs_pkg::CNT_BITS;
    localparam int PB = wbcs_pkg::PROD_BITS;
    localparam int XB = wbcs_pkg::COL_BITS;
    localparam int CS = wbcs_pkg::CSUM_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_PIX, S_MOD, S_SEL, S_RD, S_DGO, S_DWAIT, S_DONE
    } t_state;

    t_state            r_state;
    wbcs_pkg::t_cfg    r_cfg;
    logic [DB-1:0]     r_col, r_row;
    wbcs_pkg::t_pixel  r_pix;
    logic [LB-1:0]     r_pos, r_rem;
    logic [3:0]        r_step;
    logic [1:0]        r_color;
    logic [XB-1:0]     r_res_b, r_res_g, r_res_r;
    logic              r_out_valid;
    logic [XB-1:0]     r_out_b, r_out_g, r_out_r;

    logic              w_in_acc, w_pix_ok, w_start, w_frame;
    logic [LB-1:0]     w_total;
    logic [19:0]       w_cand;
    logic [LB:0]       w_sum;
    logic [LB-1:0]     w_led;
    logic              w_led_ok, w_rd_valid;
    logic              w_hit_valid, w_scan_busy;
    logic [AW-1:0]     w_hit_idx;
    logic              w_acc_ready, w_rd_done, w_live, w_mem_ready;
    wbcs_pkg::t_entry  w_entry;
    logic              w_div_start, w_div_done;
    logic [CS-1:0]     w_div_sum;
    logic [XB-1:0]     w_mean;

    assign o_in_ready  = (r_state == S_IDLE) && w_mem_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_led_blue  = r_out_b;
    assign o_led_green = r_out_g;
    assign o_led_red   = r_out_r;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_total  = LB'(r_cfg.top) + LB'(r_cfg.right) + LB'(r_cfg.bottom) + LB'(r_cfg.left);
    assign w_pix_ok = (r_cfg.width != '0) && (r_cfg.height != '0) &&
                      (r_row < r_cfg.height) && (r_col < r_cfg.width);
    assign w_start  = w_in_acc && (i_action == wbcs_pkg::ACT_PIXEL) && w_pix_ok;
    assign w_frame  = w_in_acc && (i_action == wbcs_pkg::ACT_FRAME);

    assign w_cand   = 20'(w_total) << r_step;
    assign w_sum    = (LB+1)'(r_pos) + (LB+1)'(w_total) - (LB+1)'(r_rem);
    assign w_led    = (w_sum >= (LB+1)'(w_total)) ? LB'(w_sum - (LB+1)'(w_total)) : LB'(w_sum);
    assign w_led_ok = int'(w_led) < MAX_LEDS;
    assign w_rd_valid = (r_state == S_SEL) && w_led_ok;

    assign w_div_start = r_state == S_DGO;
    always_comb begin
        case (r_color)
            2'd0:    w_div_sum = w_entry.bsum;
            2'd1:    w_div_sum = w_entry.gsum;
            default: w_div_sum = w_entry.rsum;
        endcase
    end

    wbcs_scan #(.MAX_LEDS(MAX_LEDS)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_cfg       (r_cfg),
        .i_x         (r_col),
        .i_y         (r_row),
        .i_hit_ready (w_acc_ready),
        .o_hit_valid (w_hit_valid),
        .o_hit_idx   (w_hit_idx),
        .o_busy      (w_scan_busy)
    );

    wbcs_mem #(.MAX_LEDS(MAX_LEDS)) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (w_frame),
        .i_acc_valid (w_hit_valid),
        .i_acc_idx   (w_hit_idx),
        .i_pix       (r_pix),
        .o_acc_ready (w_acc_ready),
        .i_rd_valid  (w_rd_valid),
        .i_rd_idx    (AW'(w_led)),
        .o_rd_done   (w_rd_done),
        .o_entry     (w_entry),
        .o_live      (w_live),
        .o_ready     (w_mem_ready)
    );

    wbcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_div_sum),
        .i_wgt   (w_entry.wsum),
        .o_done  (w_div_done),
        .o_mean  (w_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= wbcs_pkg::RST_WIDTH;
            r_cfg.height <= wbcs_pkg::RST_HEIGHT;
            r_cfg.thick  <= wbcs_pkg::RST_THICK;
            r_cfg.top    <= wbcs_pkg::RST_TOP;
            r_cfg.right  <= wbcs_pkg::RST_RIGHT;
            r_cfg.bottom <= wbcs_pkg::RST_BOTTOM;
            r_cfg.left   <= wbcs_pkg::RST_LEFT;
            r_cfg.shift  <= wbcs_pkg::RST_SHIFT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wbcs_pkg::REG_WIDTH:  r_cfg.width  <= i_cfg_data;
                wbcs_pkg::REG_HEIGHT: r_cfg.height <= i_cfg_data;
                wbcs_pkg::REG_THICK:  r_cfg.thick  <= i_cfg_data;
                wbcs_pkg::REG_TOP:    r_cfg.top    <= i_cfg_data[CB-1:0];
                wbcs_pkg::REG_RIGHT:  r_cfg.right  <= i_cfg_data[CB-1:0];
                wbcs_pkg::REG_BOTTOM: r_cfg.bottom <= i_cfg_data[CB-1:0];
                wbcs_pkg::REG_LEFT:   r_cfg.left   <= i_cfg_data[CB-1:0];
                wbcs_pkg::REG_SHIFT:  r_cfg.shift  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_action)
                            wbcs_pkg::ACT_PIXEL: begin
                                if (w_pix_ok) begin
                                    r_pix.wgt    <= i_pixel_weight;
                                    r_pix.prod_b <= PB'(i_pixel_weight) * PB'(i_pixel_blue);
                                    r_pix.prod_g <= PB'(i_pixel_weight) * PB'(i_pixel_green);
                                    r_pix.prod_r <= PB'(i_pixel_weight) * PB'(i_pixel_red);
                                    if (r_col + DB'(1) >= r_cfg.width) begin
                                        r_col <= '0;
                                        r_row <= r_row + DB'(1);
                                    end else begin
                                        r_col <= r_col + DB'(1);
                                    end
                                    r_state <= S_PIX;
                                end
                            end
                            wbcs_pkg::ACT_FRAME: begin
                                r_col <= '0;
                                r_row <= '0;
                            end
                            wbcs_pkg::ACT_READ: begin
                                r_pos <= i_strip_index;
                                if ((w_total == '0) || (i_strip_index >= w_total)) begin
                                    r_res_b <= '0;
                                    r_res_g <= '0;
                                    r_res_r <= '0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_rem   <= r_cfg.shift;
                                    r_step  <= 4'(LB - 1);
                                    r_state <= S_MOD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PIX: begin
                    if (!w_scan_busy && w_acc_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_MOD: begin
                    if (20'(r_rem) >= w_cand) begin
                        r_rem <= r_rem - w_cand[LB-1:0];
                    end
                    r_step <= r_step - 4'd1;
                    if (r_step == 4'd0) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (w_led_ok) begin
                        r_state <= S_RD;
                    end else begin
                        r_res_b <= '0;
                        r_res_g <= '0;
                        r_res_r <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_RD: begin
                    if (w_rd_done) begin
                        if (w_live && (w_entry.wsum != '0)) begin
                            r_color <= 2'd0;
                            r_state <= S_DGO;
                        end else begin
                            r_res_b <= '0;
                            r_res_g <= '0;
                            r_res_r <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_done) begin
                        case (r_color)
                            2'd0:    r_res_b <= w_mean;
                            2'd1:    r_res_g <= w_mean;
                            default: r_res_r <= w_mean;
                        endcase
                        if (r_color == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_color <= r_color + 2'd1;
                            r_state <= S_DGO;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_b     <= r_res_b;
                        r_out_g     <= r_res_g;
                        r_out_r     <= r_res_r;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/wbcs_checker.sv =====
// Port-level checks of the weighted border color sampler and their binding to the top level.
module wbcs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [1:0]                    i_action,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [wbcs_pkg::COL_BITS-1:0] o_led_blue,
    input logic [wbcs_pkg::COL_BITS-1:0] o_led_green,
    input logic [wbcs_pkg::COL_BITS-1:0] o_led_red
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> i_in_valid)
        else $error("Input valid dropped before its transaction completed.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_led_blue) && $stable(o_led_green) &&
             $stable(o_led_red)))
        else $error("Stalled output transaction changed.");

    a_reset_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_in_ready && !o_out_valid))
        else $error("Block ready or showing a result right after reset.");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_action == wbcs_pkg::ACT_READ)) |=> !o_in_ready)
        else $error("Read transaction did not hold off the next input.");

endmodule

bind weighted_border_color_sampler wbcs_checker u_wbcs_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the weighted border color sampler with its own color predictor.
module testbench;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_color;

    typedef struct {
        wbcs_pkg::t_action act;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [15:0] w;
        logic [9:0] idx;
        bit         fixed;
        t_color     fx;
    } t_stim;

    localparam int ITEMS = 1550;
    localparam longint unsigned WMAX = 64'hFFFF_FFFF;
    localparam longint unsigned CMAX = 64'hFF_FFFF_FFFF;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_action = wbcs_pkg::ACT_NONE;
    logic [7:0]  i_pixel_blue = 0;
    logic [7:0]  i_pixel_green = 0;
    logic [7:0]  i_pixel_red = 0;
    logic [15:0] i_pixel_weight = 16'd256;
    logic [9:0]  i_strip_index = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [7:0]  o_led_blue;
    logic [7:0]  o_led_green;
    logic [7:0]  o_led_red;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 0;
    logic [9:0]  i_cfg_data = 0;

    weighted_border_color_sampler u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    int unsigned     cw, ch, cd, ct, cr, cb, cl, cs;
    longint unsigned wsum[1024];
    longint unsigned bsum[1024];
    longint unsigned gsum[1024];
    longint unsigned rsum[1024];
    bit              tag[1024];
    bit              parity;
    int unsigned     col, row;

    t_color colors_due[$];
    int     fails = 0;
    int     items_sent = 0;
    int     reads_done = 0;
    int     phases = 0;
    bit     calm = 0;
    int     out_stall = 0;

    function automatic int unsigned bnd(int unsigned k, int unsigned dim, int unsigned n);
        return 32'((64'd2 * k * dim + n) / (64'd2 * n));
    endfunction

    function automatic bit in_span(int unsigned p, int unsigned k, int unsigned dim,
                                   int unsigned n);
        int unsigned a, e, len;
        a = bnd(k, dim, n);
        e = bnd(k + 1, dim, n);
        len = (e > a) ? e - a : 1;
        return p >= a && p < a + len;
    endfunction

    function automatic longint unsigned sat(longint unsigned s, longint unsigned v,
                                            longint unsigned cap);
        s = s + v;
        return (s > cap) ? cap : s;
    endfunction

    function automatic void accumulate(int unsigned k, logic [7:0] b, logic [7:0] g,
                                       logic [7:0] r, logic [15:0] w);
        if (k >= 1024) return;
        if (tag[k] != parity) begin
            tag[k] = parity;
            wsum[k] = 0;
            bsum[k] = 0;
            gsum[k] = 0;
            rsum[k] = 0;
        end
        wsum[k] = sat(wsum[k], 64'(w), WMAX);
        bsum[k] = sat(bsum[k], 64'(b) * 64'(w), CMAX);
        gsum[k] = sat(gsum[k], 64'(g) * 64'(w), CMAX);
        rsum[k] = sat(rsum[k], 64'(r) * 64'(w), CMAX);
    endfunction

    function automatic void take_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                       logic [15:0] w);
        int unsigned x, y, i;
        x = col;
        y = row;
        if (cw == 0 || ch == 0 || y >= ch || x >= cw) return;
        if (y < ((cd < ch) ? cd : ch))
            for (i = 0; i < ct; i++)
                if (in_span(x, i, cw, ct)) accumulate(i, b, g, r, w);
        if (x >= ((cw > cd) ? cw - cd : 0))
            for (i = 0; i < cr; i++)
                if (in_span(y, i, ch, cr)) accumulate(ct + i, b, g, r, w);
        if (y >= ((ch > cd) ? ch - cd : 0))
            for (i = 0; i < cb; i++)
                if (in_span(x, cb - 1 - i, cw, cb)) accumulate(ct + cr + i, b, g, r, w);
        if (x < ((cd < cw) ? cd : cw))
            for (i = 0; i < cl; i++)
                if (in_span(y, cl - 1 - i, ch, cl))
                    accumulate(ct + cr + cb + i, b, g, r, w);
        x++;
        if (x >= cw) begin
            x = 0;
            y++;
        end
        col = x & 32'h3FF;
        row = y & 32'h3FF;
    endfunction

    function automatic logic [7:0] mean8(longint unsigned s, longint unsigned w);
        longint unsigned m;
        m = (64'd2 * s + w) / (64'd2 * w);
        return (m > 255) ? 8'd255 : m[7:0];
    endfunction

    function automatic t_color read_color(int unsigned p);
        int unsigned n, k;
        t_color c;
        n = ct + cr + cb + cl;
        c = '0;
        if (n != 0 && p < n) begin
            k = (p + n - cs % n) % n;
            if (k < 1024 && tag[k] == parity && wsum[k] != 0) begin
                c.b = mean8(bsum[k], wsum[k]);
                c.g = mean8(gsum[k], wsum[k]);
                c.r = mean8(rsum[k], wsum[k]);
            end
        end
        return c;
    endfunction

    function automatic int unsigned led_total();
        return ct + cr + cb + cl;
    endfunction

    task automatic put_item(wbcs_pkg::t_action a, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r, logic [15:0] w, logic [9:0] p, bit fixed,
                            t_color fx);
        t_color c;
        i_action = a;
        i_pixel_blue = b;
        i_pixel_green = g;
        i_pixel_red = r;
        i_pixel_weight = w;
        i_strip_index = p;
        i_in_valid = 1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        case (a)
            wbcs_pkg::ACT_PIXEL: take_pixel(b, g, r, w);
            wbcs_pkg::ACT_FRAME: begin
                parity ^= 1'b1;
                col = 0;
                row = 0;
            end
            wbcs_pkg::ACT_READ: begin
                c = read_color(32'(p));
                colors_due.push_back(fixed ? fx : c);
                reads_done++;
            end
            default: ;
        endcase
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] k, int unsigned v);
        i_cfg_index = k;
        i_cfg_data = v[9:0];
        i_cfg_valid = 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (k)
            wbcs_pkg::REG_WIDTH:  cw = v & 32'h3FF;
            wbcs_pkg::REG_HEIGHT: ch = v & 32'h3FF;
            wbcs_pkg::REG_THICK:  cd = v & 32'h3FF;
            wbcs_pkg::REG_TOP:    ct = v & 32'hFF;
            wbcs_pkg::REG_RIGHT:  cr = v & 32'hFF;
            wbcs_pkg::REG_BOTTOM: cb = v & 32'hFF;
            wbcs_pkg::REG_LEFT:   cl = v & 32'hFF;
            default:              cs = v & 32'h3FF;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        i_in_valid = 0;
        while (colors_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3 * led_total() + 150) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_all(int unsigned w, int unsigned h, int unsigned d, int unsigned t,
                           int unsigned r, int unsigned b, int unsigned l, int unsigned s);
        write_reg(wbcs_pkg::REG_WIDTH, w);
        write_reg(wbcs_pkg::REG_HEIGHT, h);
        write_reg(wbcs_pkg::REG_THICK, d);
        write_reg(wbcs_pkg::REG_TOP, t);
        write_reg(wbcs_pkg::REG_RIGHT, r);
        write_reg(wbcs_pkg::REG_BOTTOM, b);
        write_reg(wbcs_pkg::REG_LEFT, l);
        write_reg(wbcs_pkg::REG_SHIFT, s);
        phases++;
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 16'd256;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(256, 65535));
        endcase
    endfunction

    task automatic rand_pixel();
        put_item(wbcs_pkg::ACT_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), rand_weight(), 10'($urandom), 0, '0);
    endtask

    task automatic rand_read(int unsigned p);
        put_item(wbcs_pkg::ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 10'(p), 0, '0);
    endtask

    // One frame, mostly well formed, with noise mixed in, then reads of the strip.
    task automatic run_frame(int unsigned pix_cap, int unsigned read_cap);
        int unsigned npix, n, i;
        npix = (cw * ch == 0) ? 10 : cw * ch;
        if (npix > pix_cap) npix = pix_cap;
        put_item(wbcs_pkg::ACT_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 10'($urandom), 0, '0);
        for (i = 0; i < npix; i++) begin
            case ($urandom_range(0, 29))
                0: put_item(wbcs_pkg::ACT_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                            16'($urandom), 10'($urandom), 0, '0);
                1: rand_read($urandom_range(0, 1023));
                2: if ($urandom_range(0, 3) == 0)
                       put_item(wbcs_pkg::ACT_FRAME, 8'($urandom), 8'($urandom),
                                8'($urandom), 16'($urandom), 10'($urandom), 0, '0);
                default: ;
            endcase
            rand_pixel();
        end
        repeat ($urandom_range(0, 3)) rand_pixel();
        n = led_total();
        if (n <= 60)
            for (i = 0; i < n; i++) rand_read(i);
        else
            repeat (read_cap) rand_read($urandom_range(0, n - 1));
        rand_read($urandom_range(0, 1023));
        rand_read(n + $urandom_range(0, 3));
    endtask

    function automatic int unsigned pick_count();
        return ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    function automatic t_stim stim_row(wbcs_pkg::t_action a, int unsigned b,
                                       int unsigned g, int unsigned r, int unsigned w,
                                       int unsigned p, bit fixed, int unsigned eb,
                                       int unsigned eg, int unsigned er);
        t_stim s;
        s.act = a;
        s.b = 8'(b);
        s.g = 8'(g);
        s.r = 8'(r);
        s.w = 16'(w);
        s.idx = 10'(p);
        s.fixed = fixed;
        s.fx.b = 8'(eb);
        s.fx.g = 8'(eg);
        s.fx.r = 8'(er);
        return s;
    endfunction

    always @(negedge i_clk) begin
        if (calm) begin
            i_out_ready = 1;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready = 0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(0, 5);
            i_out_ready = 0;
        end else begin
            i_out_ready = 1;
        end
    end

    always @(posedge i_clk) begin
        t_color due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (colors_due.size() == 0) begin
                $error("color transaction with none expected");
                fails++;
            end else begin
                due = colors_due.pop_front();
                if (o_led_blue !== due.b) begin
                    $error("led_blue expected %0d actual %0d", due.b, o_led_blue);
                    fails++;
                end
                if (o_led_green !== due.g) begin
                    $error("led_green expected %0d actual %0d", due.g, o_led_green);
                    fails++;
                end
                if (o_led_red !== due.r) begin
                    $error("led_red expected %0d actual %0d", due.r, o_led_red);
                    fails++;
                end
            end
        end
    end

    initial begin
        #30000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_stim dir_rows[$];
        int unsigned w, h, t, r, b, l;
        cw = 32'(wbcs_pkg::RST_WIDTH);
        ch = 32'(wbcs_pkg::RST_HEIGHT);
        cd = 32'(wbcs_pkg::RST_THICK);
        ct = 32'(wbcs_pkg::RST_TOP);
        cr = 32'(wbcs_pkg::RST_RIGHT);
        cb = 32'(wbcs_pkg::RST_BOTTOM);
        cl = 32'(wbcs_pkg::RST_LEFT);
        cs = 32'(wbcs_pkg::RST_SHIFT);
        for (int k = 0; k < 1024; k++) begin
            wsum[k] = 0;
            bsum[k] = 0;
            gsum[k] = 0;
            rsum[k] = 0;
            tag[k] = 0;
        end
        parity = 1;
        col = 0;
        row = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Default settings: 320x180 frame, 50 LEDs, the first pixel hits top LED 0 and
        // the last left LED.
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 256, 0, 1, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 256, 1023, 1, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_NONE, 255, 255, 255, 65535, 1023, 0,
                                    0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_PIXEL, 255, 0, 128, 65535, 0, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 0, 1, 255, 0, 128));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 49, 1, 255, 0, 128));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 50, 1, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_PIXEL, 0, 255, 1, 256, 0, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_PIXEL, 1, 2, 3, 300, 0, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_PIXEL, 200, 100, 50, 40000, 0, 0,
                                    0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 49, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_PIXEL, 7, 8, 9, 65535, 0, 0, 0, 0, 0));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 0, 1, 7, 8, 9));
        dir_rows.push_back(stim_row(wbcs_pkg::ACT_READ, 0, 0, 0, 0, 49, 1, 7, 8, 9));
        foreach (dir_rows[k])
            put_item(dir_rows[k].act, dir_rows[k].b, dir_rows[k].g, dir_rows[k].r,
                     dir_rows[k].w, dir_rows[k].idx, dir_rows[k].fixed, dir_rows[k].fx);
        settle();

        // Extreme settings.
        set_all(1023, 1, 1023, 1, 1, 1, 1, 1019);
        run_frame(60, 10);
        settle();
        set_all(2, 2, 1, 255, 255, 255, 255, 1019);
        run_frame(4, 12);
        rand_read(1019);
        settle();
        set_all(1, 1023, 1, 2, 3, 1, 2, 5);
        run_frame(40, 10);
        settle();
        set_all(0, 5, 3, 2, 2, 2, 2, 0);
        run_frame(6, 10);
        settle();

        while (items_sent < ITEMS) begin
            if (items_sent > ITEMS - 150) calm = 1;
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 12);
            t = pick_count();
            r = pick_count();
            b = pick_count();
            l = pick_count();
            set_all(w, h, $urandom_range(1, (w > h ? w : h) + 1), t, r, b, l,
                    $urandom_range(0, 1019));
            run_frame(150, 20);
            settle();
        end
        calm = 1;
        settle();

        if (colors_due.size() != 0) begin
            $error("%0d expected colors never arrived", colors_due.size());
            fails++;
        end
        $display("Ran %0d transactions over %0d settings, %0d colors read back.",
                 items_sent, phases, reads_done);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/wbcs_pkg.sv
hdl/wbcs_scan.sv
hdl/wbcs_mem.sv
hdl/wbcs_div.sv
hdl/weighted_border_color_sampler.sv
hdl/wbcs_checker.sv
tb/sv/testbench.sv
